[rtl/core/ftar_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftar_pkg
// Shared constants, codes and types for the fat-tree aggregation route core.
// ----------------------------------------------------------------------------
package ftar_pkg;

    localparam int PORTS      = 8;
    localparam int LOAD_BITS  = 8;

    localparam int UP_PORTS   = PORTS / 2;
    localparam int DOWN_PORTS = PORTS / 2;
    localparam int NODE_SPAN  = DOWN_PORTS * DOWN_PORTS;

    // fixed field widths
    localparam int FUNC_W  = 3;
    localparam int SRC_W   = 3;
    localparam int DEST_W  = 10;
    localparam int LOADS_W = 32;
    localparam int MASK_W  = 8;
    localparam int ERR_W   = 3;
    localparam int SWID_W  = 8;

    localparam int PORT_IDX_W = $clog2(PORTS);
    localparam int UP_IDX_W   = (UP_PORTS > 1) ? $clog2(UP_PORTS) : 1;
    localparam int BASE_W     = SWID_W + $clog2(DOWN_PORTS) + 2;
    localparam int CMP_W      = (SRC_W > PORT_IDX_W) ? SRC_W + 1 : PORT_IDX_W + 1;

    localparam logic [PORTS-1:0] ALL_UP_MASK   = PORTS'((1 << UP_PORTS) - 1);
    localparam logic [PORTS-1:0] ALL_DOWN_MASK =
        PORTS'(((1 << DOWN_PORTS) - 1) << UP_PORTS);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_DIRECT    = 3'd0,
        FUNC_BROADCAST = 3'd1,
        FUNC_BAR_REQ   = 3'd2,
        FUNC_BAR_REL   = 3'd3,
        FUNC_GATHER    = 3'd4
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK               = 3'd0,
        ERR_BAR_REQ_FROM_UP  = 3'd1,
        ERR_REL_FROM_DOWN    = 3'd2,
        ERR_GATHER_TO_SRC    = 3'd3,
        ERR_GATHER_UP_REMOTE = 3'd4
    } err_t;

    typedef struct packed {
        logic [PORTS-1:0] port_mask;
        err_t             error;
    } route_result_t;

endpackage : ftar_pkg
`default_nettype wire

[rtl/core/fat_tree_aggregate_route_and_barrier_core.sv]
`default_nettype none
// Pipeline: an accepted input beat passes the input register, then the result
//   register, before it shows on out_valid.
// One header per cycle unless out_stall; the decision is one pass of logic.
// Reset clears both valid flags, the barrier release flags and switch_id.
// ----------------------------------------------------------------------------
// fat_tree_aggregate_route_and_barrier_core
// Fat-tree aggregation switch routing stage: port mask and error per header.
// ----------------------------------------------------------------------------
module fat_tree_aggregate_route_and_barrier_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ftar_pkg::SWID_W-1:0]  cfg_data,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [ftar_pkg::FUNC_W-1:0]  func,
    input  wire logic [ftar_pkg::SRC_W-1:0]   source_port,
    input  wire logic [ftar_pkg::DEST_W-1:0]  destination,
    input  wire logic [ftar_pkg::LOADS_W-1:0] up_loads,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [ftar_pkg::MASK_W-1:0]  port_mask,
    output logic      [ftar_pkg::ERR_W-1:0]   error
);
    import ftar_pkg::*;

    logic                 in_valid_reg;
    logic [FUNC_W-1:0]    func_reg;
    logic [SRC_W-1:0]     source_port_reg;
    logic [DEST_W-1:0]    destination_reg;
    logic [LOADS_W-1:0]   up_loads_reg;

    logic                 out_valid_reg;
    route_result_t        out_result_reg;

    logic [SWID_W-1:0]    switch_id_reg;
    logic [UP_PORTS-1:0]  release_seen_reg;
    logic [UP_PORTS-1:0]  release_seen_next;

    route_result_t        result;
    logic                 out_advance;
    logic                 in_accept;
    logic                 step;

    assign cfg_ready   = 1'b1;
    assign out_advance = !out_valid_reg || !out_stall;
    assign in_stall    = in_valid_reg && !out_advance;
    assign in_accept   = in_valid && !in_stall;
    assign step        = in_valid_reg && out_advance;

    ftar_route_decide u_decide (
        .func              (func_reg),
        .source_port       (source_port_reg),
        .destination       (destination_reg),
        .up_loads          (up_loads_reg),
        .switch_id         (switch_id_reg),
        .release_seen      (release_seen_reg),
        .result            (result),
        .release_seen_next (release_seen_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            switch_id_reg    <= '0;
            release_seen_reg <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_advance)
                out_valid_reg <= in_valid_reg;
            if (cfg_valid && cfg_ready)
                switch_id_reg <= cfg_data;
            // flags move only when the header leaves for the result register
            if (step)
                release_seen_reg <= release_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg        <= func;
            source_port_reg <= source_port;
            destination_reg <= destination;
            up_loads_reg    <= up_loads;
        end
        if (step)
            out_result_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign port_mask = MASK_W'(out_result_reg.port_mask);
    assign error     = ERR_W'(out_result_reg.error);

endmodule : fat_tree_aggregate_route_and_barrier_core
`default_nettype wire

[rtl/core/ftar_least_loaded.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftar_least_loaded
// Picks the up port with the smallest queue load, lowest index on ties.
// ----------------------------------------------------------------------------
module ftar_least_loaded (
    input  wire logic [ftar_pkg::LOADS_W-1:0] up_loads,
    output logic      [ftar_pkg::PORTS-1:0]   up_one
);
    import ftar_pkg::*;

    logic [LOAD_BITS-1:0] load_arr [UP_PORTS];
    logic [LOAD_BITS-1:0] best_load;
    logic [UP_IDX_W-1:0]  best_idx;

    // a load field past the top of the input word reads as zero
    always_comb
    begin
        for (int i = 0; i < UP_PORTS; i++)
        begin
            if (i * LOAD_BITS >= LOADS_W)
                load_arr[i] = '0;
            else
                load_arr[i] = LOAD_BITS'(up_loads >> (i * LOAD_BITS));
        end
    end

    always_comb
    begin
        best_load = load_arr[0];
        best_idx  = '0;
        for (int i = 1; i < UP_PORTS; i++)
        begin
            if (load_arr[i] < best_load)
            begin
                best_load = load_arr[i];
                best_idx  = UP_IDX_W'(i);
            end
        end
        up_one = PORTS'(1) << best_idx;
    end

endmodule : ftar_least_loaded
`default_nettype wire

[rtl/core/ftar_route_decide.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ftar_route_decide
// Output-port decision for one header, plus barrier release flag update.
// ----------------------------------------------------------------------------
module ftar_route_decide (
    input  wire logic [ftar_pkg::FUNC_W-1:0]   func,
    input  wire logic [ftar_pkg::SRC_W-1:0]    source_port,
    input  wire logic [ftar_pkg::DEST_W-1:0]   destination,
    input  wire logic [ftar_pkg::LOADS_W-1:0]  up_loads,
    input  wire logic [ftar_pkg::SWID_W-1:0]   switch_id,
    input  wire logic [ftar_pkg::UP_PORTS-1:0] release_seen,
    output ftar_pkg::route_result_t            result,
    output logic      [ftar_pkg::UP_PORTS-1:0] release_seen_next
);
    import ftar_pkg::*;

    logic [PORTS-1:0]      up_one;
    logic [BASE_W-1:0]     base;
    logic [BASE_W-1:0]     dest_x;
    logic [BASE_W-1:0]     offset;
    logic                  is_local;
    logic                  from_down;
    logic                  src_real;
    logic [PORT_IDX_W-1:0] target;
    logic [PORTS-1:0]      target_one;
    logic                  target_is_src;
    logic [UP_PORTS-1:0]   rel_set;
    logic [PORTS-1:0]      flood;

    ftar_least_loaded u_least_loaded (
        .up_loads (up_loads),
        .up_one   (up_one)
    );

    always_comb
    begin
        base      = BASE_W'(switch_id / DOWN_PORTS) * BASE_W'(NODE_SPAN);
        dest_x    = BASE_W'(destination);
        is_local  = (dest_x >= base) && (dest_x < base + BASE_W'(NODE_SPAN));
        offset    = dest_x - base;
        target    = PORT_IDX_W'(UP_PORTS) + PORT_IDX_W'(offset / DOWN_PORTS);
        target_one = PORTS'(1) << target;
        target_is_src = CMP_W'(target) == CMP_W'(source_port);

        from_down = CMP_W'(source_port) >= CMP_W'(UP_PORTS);
        src_real  = CMP_W'(source_port) <  CMP_W'(PORTS);

        // broadcast from below: all down ports plus one up port, minus the arrival port
        flood = ALL_DOWN_MASK | up_one;
        if (src_real)
            flood = flood & ~(PORTS'(1) << source_port);

        rel_set = release_seen | (UP_PORTS'(1) << source_port);

        result.port_mask  = '0;
        result.error      = ERR_OK;
        release_seen_next = release_seen;

        unique case (func)
            FUNC_DIRECT:
            begin
                result.port_mask = is_local ? target_one : up_one;
            end
            FUNC_BROADCAST:
            begin
                result.port_mask = from_down ? flood : ALL_DOWN_MASK;
            end
            FUNC_BAR_REQ:
            begin
                if (from_down)
                    result.port_mask = ALL_UP_MASK;
                else
                    result.error = ERR_BAR_REQ_FROM_UP;
            end
            FUNC_BAR_REL:
            begin
                if (from_down)
                    result.error = ERR_REL_FROM_DOWN;
                else if (&rel_set)
                begin
                    result.port_mask  = ALL_DOWN_MASK;
                    release_seen_next = '0;
                end
                else
                    release_seen_next = rel_set;
            end
            FUNC_GATHER:
            begin
                if (from_down)
                begin
                    if (!is_local)
                        result.port_mask = up_one;
                    else if (target_is_src)
                        result.error = ERR_GATHER_TO_SRC;
                    else
                        result.port_mask = target_one;
                end
                else if (is_local)
                    result.port_mask = target_one;
                else
                    result.error = ERR_GATHER_UP_REMOTE;
            end
            default:
            begin
                result.port_mask = '0;
            end
        endcase
    end

endmodule : ftar_route_decide
`default_nettype wire
